// File: rtl/assert_macros.svh
// Assertion helpers shared by gpr_queue and gpr_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off during reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/gpr_pkg.sv
package gpr_pkg;

   localparam int MAX_DEGREE_DEFAULT = 32;
   localparam int COEF_COUNT         = 32;
   localparam int COEF_BITS          = COEF_COUNT * 8;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [2:0] {
      CSR_FIELD_POLY = 3'd0,
      CSR_DEGREE     = 3'd1,
      CSR_COEFS_A    = 3'd2,
      CSR_COEFS_B    = 3'd3,
      CSR_COEFS_C    = 3'd4,
      CSR_COEFS_D    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0]           poly;
      logic [5:0]           degree;
      logic [COEF_BITS-1:0] coefs;
   } gpr_cfg_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] red);
      logic [7:0] x;
      logic [7:0] acc;
      logic       carry;
      x   = a;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         carry = x[7];
         x     = {x[6:0], 1'b0};
         if (carry) x = x ^ red;
      end
      return acc;
   endfunction

endpackage

// File: rtl/gpr_front.sv
module gpr_front import gpr_pkg::*; #(
   parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gpr_cfg_type             cfg,
   input  logic                    space,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tlast,
   output logic                    push,
   output logic [MAX_DEGREE*8-1:0] push_data
);

   logic [7:0] window_ff [MAX_DEGREE];
   logic [7:0] window_in [MAX_DEGREE];
   logic [7:0] upd       [MAX_DEGREE];
   logic [7:0] quot;
   logic       accept;

   assign req_tready = space;
   assign accept     = req_tvalid && space;
   assign quot       = window_ff[0];
   assign push       = accept && req_tlast && (cfg.degree != '0);

   always_comb begin
      for (int k = 0; k < MAX_DEGREE; k++) begin
         if (k + 1 < int'(cfg.degree)) begin
            upd[k] = window_ff[k+1 < MAX_DEGREE ? k+1 : k];
         end else if (k + 1 == int'(cfg.degree)) begin
            upd[k] = req_tdata;
         end else begin
            upd[k] = window_ff[k];
         end
         if (k < int'(cfg.degree)) begin
            upd[k] = upd[k] ^ gf_mul(cfg.coefs[k*8 +: 8], quot, cfg.poly);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_DEGREE; k++) begin
         push_data[k*8 +: 8] = upd[k];
         if (!accept) begin
            window_in[k] = window_ff[k];
         end else if (req_tlast) begin
            window_in[k] = '0;
         end else begin
            window_in[k] = upd[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_DEGREE; k++) begin
         window_ff[k] <= reset ? 8'd0 : window_in[k];
      end
   end

endmodule

// File: rtl/gpr_queue.sv
`include "assert_macros.svh"

module gpr_queue import gpr_pkg::*; #(
   parameter int WIDTH = MAX_DEGREE_DEFAULT * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_CLK(a_queue_no_overflow, push |-> !full, "write into full parity queue")
   `ASSERT_CLK(a_queue_no_underflow, pop |-> !empty, "read from empty parity queue")

endmodule

// File: rtl/gpr_back.sv
`include "assert_macros.svh"

module gpr_back import gpr_pkg::*; #(
   parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [5:0]              degree,
   input  logic                    head_valid,
   input  logic [MAX_DEGREE*8-1:0] head_data,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_DEGREE + 1);

   logic [7:0]       shift_ff [MAX_DEGREE];
   logic [7:0]       shift_in [MAX_DEGREE];
   logic [CNT_W-1:0] remaining_ff, remaining_in;
   logic             accept;
   logic             load;

   assign rsp_tvalid = (remaining_ff != '0);
   assign rsp_tdata  = shift_ff[0];
   assign rsp_tlast  = (remaining_ff == CNT_W'(1));
   assign accept     = rsp_tvalid && rsp_tready;
   assign load       = head_valid && (!rsp_tvalid || (accept && rsp_tlast));
   assign pop        = load;

   always_comb begin
      remaining_in = remaining_ff;
      for (int k = 0; k < MAX_DEGREE; k++) begin
         shift_in[k] = shift_ff[k];
      end
      if (load) begin
         remaining_in = CNT_W'(degree);
         for (int k = 0; k < MAX_DEGREE; k++) begin
            shift_in[k] = head_data[k*8 +: 8];
         end
      end else if (accept) begin
         remaining_in = remaining_ff - 1'b1;
         for (int k = 0; k + 1 < MAX_DEGREE; k++) begin
            shift_in[k] = shift_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_DEGREE; k++) begin
         shift_ff[k] <= shift_in[k];
      end
   end

   `ASSERT_CLK(a_back_load_count, load |=> remaining_ff == CNT_W'($past(degree)),
               "parity burst length differs from degree")
   `ASSERT_CLK(a_back_load_nonzero, load |-> degree != '0,
               "empty parity burst queued")

endmodule

// File: rtl/gf256_polynomial_remainder.sv
// GF(2^8) polynomial remainder (Reed-Solomon systematic parity generator).
// Request channel: one dividend symbol per transaction, highest order first,
// req_tlast on the final symbol of a message. The block then returns n
// remainder symbols on the response channel, highest order first, with
// rsp_tlast on the last one (n = divisor degree, capped at MAX_DEGREE).
// Configuration channel: csr_index selects field polynomial, degree or one
// of four 64-bit coefficient banks; write only while the block is idle.
// Throughput: one symbol per cycle on the request side while the queue has
// space, one parity symbol per cycle on the response side while rsp_tready
// is high. Each window update (n parallel GF multiplies) is registered; the
// final parity word goes to the queue, then to the output shifter, which
// presents the first parity symbol. A two-entry queue of finished parity
// words sits between the update stage and the output shifter; when it is
// full (messages shorter than n while the output drains) req_tready drops.
// Reset clears the window, the queue and the output, and loads the
// configuration defaults. A stalled receiver holds the current symbol and
// lets the queue fill before backpressure reaches the request side.
module gf256_polynomial_remainder import gpr_pkg::*; #(
   parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] dividend_symbol
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] remainder_symbol
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [8:0]              poly_ff, poly_in;
   logic [5:0]              degree_ff, degree_in;
   logic [63:0]             coefs_ff [4];
   logic [63:0]             coefs_in [4];
   gpr_cfg_type             cfg;
   logic                    push;
   logic                    pop;
   logic                    full;
   logic                    empty;
   logic [MAX_DEGREE*8-1:0] push_data;
   logic [MAX_DEGREE*8-1:0] head_data;

   assign csr_ready = 1'b1;

   always_comb begin
      poly_in   = poly_ff;
      degree_in = degree_ff;
      for (int i = 0; i < 4; i++) begin
         coefs_in[i] = coefs_ff[i];
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIELD_POLY: poly_in     = csr_data[8:0];
            CSR_DEGREE:     degree_in   = csr_data[5:0];
            CSR_COEFS_A:    coefs_in[0] = csr_data;
            CSR_COEFS_B:    coefs_in[1] = csr_data;
            CSR_COEFS_C:    coefs_in[2] = csr_data;
            CSR_COEFS_D:    coefs_in[3] = csr_data;
            default:        poly_in     = poly_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff   <= 9'd285;
         degree_ff <= 6'd16;
         for (int i = 0; i < 4; i++) begin
            coefs_ff[i] <= '0;
         end
      end else begin
         poly_ff   <= poly_in;
         degree_ff <= degree_in;
         for (int i = 0; i < 4; i++) begin
            coefs_ff[i] <= coefs_in[i];
         end
      end
   end

   always_comb begin
      cfg.poly   = poly_ff[7:0];
      cfg.degree = (degree_ff > 6'(MAX_DEGREE)) ? 6'(MAX_DEGREE) : degree_ff;
      cfg.coefs  = {coefs_ff[3], coefs_ff[2], coefs_ff[1], coefs_ff[0]};
   end

   gpr_front #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .space      (!full),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_data  (push_data)
   );

   gpr_queue #(
      .WIDTH (MAX_DEGREE * 8)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .full      (full),
      .empty     (empty)
   );

   gpr_back #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .degree     (cfg.degree),
      .head_valid (!empty),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
